// ----- sv/sor_linear_solver_macros.svh -----
// Assertion macros shared by the solver checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef SOR_LINEAR_SOLVER_MACROS_SVH
`define SOR_LINEAR_SOLVER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define SOR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define SOR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sor_pkg.sv -----
// Package for the SOR linear solver: payload types, codes, reset values
// and saturation helpers. No dependencies.
`timescale 1ns / 1ps

package sor_pkg;

  localparam int unsigned DIV_NUM_W  = 64;
  localparam int unsigned DIV_DEN_W  = 34;
  localparam int unsigned SQRT_IN_W  = 64;
  localparam int unsigned SQRT_OUT_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    ACT_MATRIX = 2'd0,
    ACT_RHS    = 2'd1,
    ACT_GUESS  = 2'd2,
    ACT_START  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_BAD_DATA  = 2'd1,
    ST_ZERO_DIAG = 2'd2,
    ST_NO_CONV   = 2'd3
  } status_e;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA    = 2'd3;

  localparam logic [6:0]  SIZE_RST     = 7'd16;
  localparam logic [15:0] MAX_ITER_RST = 16'd100;
  localparam logic [31:0] TOL_RST      = 32'd66;
  localparam logic [17:0] OMEGA_RST    = 18'd65536;

  typedef struct packed {
    act_e               action;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [15:0]        iterations;
    logic [5:0]         index;
    logic signed [31:0] solution;
    logic               last;
  } out_t;

  // clamp a wide signed value to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] res;
    if (v > 66'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // unsigned add that sticks at all ones
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

// ----- sv/sor_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sor_pkg for operand widths.
`timescale 1ns / 1ps

module sor_div
  import sor_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   rem_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  // shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem_q[DIV_DEN_W-1:0], quo_q[DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == {CNT_W{1'b1}}) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- sv/sor_isqrt.sv -----
// Digit-by-digit floor square root, one result bit per cycle.
// Depends on sor_pkg for operand widths.
`timescale 1ns / 1ps

module sor_isqrt
  import sor_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SQRT_IN_W-1:0]  rad_i,
  output logic                  done_o,
  output logic [SQRT_OUT_W-1:0] root_o
);

  localparam int unsigned CNT_W = $clog2(SQRT_OUT_W);
  localparam int unsigned REM_W = SQRT_OUT_W + 3;

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [SQRT_IN_W-1:0]  rad_q;
  logic [REM_W-1:0]      rem_q;
  logic [SQRT_OUT_W-1:0] root_q;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  fits;

  // bring down two radicand bits, try root*4+1
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQRT_IN_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == {CNT_W{1'b1}}) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQRT_IN_W-3:0], 2'b00};
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[SQRT_OUT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- sv/sor_linear_solver.sv -----
// Loads are taken back to back while idle and written to their stores. A start
// transaction checks each diagonal entry, then per sweep multiplies each matrix term on
// the shared multiplier, waits on the divider once per row, then makes two square root
// waits and a division for the error; then each result is delivered.
// Throughput: one transaction at a time; stall is high until the last result leaves.
// Reset: asynchronous active low; control and configuration reset, stores do not.
`timescale 1ns / 1ps

module sor_linear_solver
  import sor_pkg::*;
#(
  parameter int MAX_SIZE  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int IW = $clog2(MAX_SIZE);
  localparam int CW = $clog2(MAX_SIZE + 1);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_CHKRD = 20'h00002,
    S_CHK   = 20'h00004,
    S_RD    = 20'h00008,
    S_MUL   = 20'h00010,
    S_ACC   = 20'h00020,
    S_RES   = 20'h00040,
    S_DIVW  = 20'h00080,
    S_MUL2  = 20'h00100,
    S_UPD   = 20'h00200,
    S_SQD   = 20'h00400,
    S_SQX   = 20'h00800,
    S_ACCX  = 20'h01000,
    S_SQ1   = 20'h02000,
    S_SQ1W  = 20'h04000,
    S_SQ2W  = 20'h08000,
    S_ERRW  = 20'h10000,
    S_ORD   = 20'h20000,
    S_OLD   = 20'h40000,
    S_OUT   = 20'h80000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [6:0]  size_q;
  logic [15:0] max_iter_q;
  logic [31:0] tol_q;
  logic [17:0] omega_q;

  // sequencer counters and datapath registers
  logic [CW-1:0]      i_q, j_q;
  logic [15:0]        sweep_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] diag_q, xi_q, xnew_q;
  logic signed [32:0] d_q;
  logic               neg_q;
  logic [63:0]        sd_q, sx_q;
  logic [31:0]        nd_q;
  status_e            status_q;
  logic signed [65:0] prod_q;
  out_t               out_q;
  logic               out_valid_q;

  // memories
  logic signed [31:0] mat_mem [2**(2*IW)];
  logic signed [31:0] rhs_mem [2**IW];
  logic signed [31:0] sol_mem [2**IW];
  logic signed [31:0] a_rd_q, b_rd_q, x_rd_q;

  logic               in_acc, out_acc, start_acc;
  logic               row_ok, col_ok;
  logic               i_last, j_last, bad_cfg;
  logic [15:0]        limit;
  logic [2*IW-1:0]    mat_raddr;
  logic [IW-1:0]      sol_raddr;
  logic               sol_we;
  logic [IW-1:0]      sol_waddr;
  logic signed [31:0] sol_wdata;

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_sh;

  // row update arithmetic
  logic signed [65:0] r_wide;
  logic signed [31:0] r_sat;
  logic [31:0]        r_mag, diag_mag;
  logic signed [31:0] g_val;
  logic signed [65:0] upd_sum;
  logic signed [31:0] xnew_val;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag, xnew_mag;

  // shared units
  logic                  div_start, div_done;
  logic [DIV_NUM_W-1:0]  div_num, div_quot;
  logic [DIV_DEN_W-1:0]  div_den;
  logic                  sq_start, sq_done;
  logic [SQRT_IN_W-1:0]  sq_rad;
  logic [SQRT_OUT_W-1:0] sq_root;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign start_acc   = in_acc && (in_data_i.action == ACT_START);
  assign out_acc     = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign row_ok = {1'b0, in_data_i.row} < 7'(MAX_SIZE);
  assign col_ok = {1'b0, in_data_i.col} < 7'(MAX_SIZE);
  assign i_last = (7'(i_q) + 7'd1) == size_q;
  assign j_last = (7'(j_q) + 7'd1) == size_q;
  assign limit  = (max_iter_q == 16'd0) ? 16'd1 : max_iter_q;

  assign bad_cfg = (omega_q == 18'd0)
                || ({14'd0, omega_q} >= (32'd2 << FRAC_BITS))
                || (size_q == 7'd0) || (size_q > 7'(MAX_SIZE))
                || (tol_q == 32'd0);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= SIZE_RST;
      max_iter_q <= MAX_ITER_RST;
      tol_q      <= TOL_RST;
      omega_q    <= OMEGA_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SIZE:     size_q     <= cfg_data_i[6:0];
        CFG_MAX_ITER: max_iter_q <= cfg_data_i[15:0];
        CFG_TOL:      tol_q      <= cfg_data_i;
        CFG_OMEGA:    omega_q    <= cfg_data_i[17:0];
        default:      size_q     <= size_q;
      endcase
    end
  end

  // memory addressing
  assign mat_raddr = (state_q == S_CHKRD || state_q == S_CHK) ?
                     {i_q[IW-1:0], i_q[IW-1:0]} : {i_q[IW-1:0], j_q[IW-1:0]};
  assign sol_raddr = (state_q == S_ORD || state_q == S_OLD || state_q == S_OUT) ?
                     i_q[IW-1:0] : j_q[IW-1:0];
  assign sol_we    = (state_q == S_UPD) ||
                     (in_acc && in_data_i.action == ACT_GUESS && row_ok);
  assign sol_waddr = (state_q == S_UPD) ? i_q[IW-1:0] : in_data_i.row[IW-1:0];
  assign sol_wdata = (state_q == S_UPD) ? xnew_val : in_data_i.value;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.action == ACT_MATRIX && row_ok && col_ok) begin
      mat_mem[{in_data_i.row[IW-1:0], in_data_i.col[IW-1:0]}] <= in_data_i.value;
    end
    a_rd_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.action == ACT_RHS && row_ok) begin
      rhs_mem[in_data_i.row[IW-1:0]] <= in_data_i.value;
    end
    b_rd_q <= rhs_mem[i_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (sol_we) begin
      sol_mem[sol_waddr] <= sol_wdata;
    end
    x_rd_q <= sol_mem[sol_raddr];
  end

  // residual and quotient handling
  assign r_wide   = {{34{b_rd_q[31]}}, b_rd_q} - {{2{acc_q[63]}}, acc_q};
  assign r_sat    = sat32(r_wide);
  assign r_mag    = r_sat[31] ? (32'd0 - r_sat) : r_sat;
  assign diag_mag = diag_q[31] ? (32'd0 - diag_q) : diag_q;

  always_comb begin
    if (!neg_q) begin
      g_val = (div_quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_quot[31:0];
    end else begin
      g_val = (div_quot > 64'h8000_0000) ? 32'sh8000_0000 : (32'd0 - div_quot[31:0]);
    end
  end

  // relaxed update and its squared terms
  assign prod_sh  = prod_q >>> FRAC_BITS;
  assign upd_sum  = {{34{xi_q[31]}}, xi_q} + prod_sh;
  assign xnew_val = sat32(upd_sum);
  assign diff     = {xi_q[31], xi_q} - {xnew_q[31], xnew_q};
  assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
  assign xnew_mag = xnew_q[31] ? (33'd0 - {1'b1, xnew_q}) : {1'b0, xnew_q};

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      S_MUL: begin
        mul_a = {a_rd_q[31], a_rd_q};
        mul_b = {x_rd_q[31], x_rd_q};
      end
      S_MUL2: begin
        mul_a = d_q;
        mul_b = {15'd0, omega_q};
      end
      S_SQD: begin
        mul_a = diff_mag;
        mul_b = diff_mag;
      end
      default: begin
        mul_a = xnew_mag;
        mul_b = xnew_mag;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // divider and square root requests
  assign div_start = (state_q == S_RES) || (state_q == S_SQ2W && sq_done);
  assign div_num   = (state_q == S_RES) ? (64'(r_mag) << FRAC_BITS)
                                        : (64'(nd_q) << FRAC_BITS);
  assign div_den   = (state_q == S_RES) ? {2'b00, diag_mag}
                                        : ({2'b00, sq_root} + (34'd1 << FRAC_BITS));
  assign sq_start  = (state_q == S_SQ1) || (state_q == S_SQ1W && sq_done);
  assign sq_rad    = (state_q == S_SQ1) ? sd_q : sx_q;

  sor_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  sor_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_acc) state_d = bad_cfg ? S_OUT : S_CHKRD;
      S_CHKRD: state_d = S_CHK;
      S_CHK: begin
        if (a_rd_q == 32'sd0) state_d = S_OUT;
        else if (i_last)      state_d = S_RD;
        else                  state_d = S_CHKRD;
      end
      S_RD:    state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = j_last ? S_RES : S_RD;
      S_RES:   state_d = S_DIVW;
      S_DIVW:  if (div_done) state_d = S_MUL2;
      S_MUL2:  state_d = S_UPD;
      S_UPD:   state_d = S_SQD;
      S_SQD:   state_d = S_SQX;
      S_SQX:   state_d = S_ACCX;
      S_ACCX:  state_d = i_last ? S_SQ1 : S_RD;
      S_SQ1:   state_d = S_SQ1W;
      S_SQ1W:  if (sq_done) state_d = S_SQ2W;
      S_SQ2W:  if (sq_done) state_d = S_ERRW;
      S_ERRW: begin
        if (div_done) begin
          if (div_quot <= {32'd0, tol_q} || (sweep_q + 16'd1) == limit) state_d = S_ORD;
          else state_d = S_RD;
        end
      end
      S_ORD:   state_d = S_OLD;
      S_OLD:   state_d = S_OUT;
      S_OUT: begin
        if (out_acc) state_d = out_q.last ? S_IDLE : S_ORD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      sweep_q     <= '0;
      status_q    <= ST_SUCCESS;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          i_q <= '0;
          if (start_acc && bad_cfg) out_valid_q <= 1'b1;
        end
        S_CHK: begin
          if (a_rd_q == 32'sd0) begin
            out_valid_q <= 1'b1;
          end else if (i_last) begin
            i_q     <= '0;
            j_q     <= '0;
            sweep_q <= '0;
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        S_ACC:  if (!j_last) j_q <= j_q + CW'(1);
        S_ACCX: begin
          j_q <= '0;
          if (!i_last) i_q <= i_q + CW'(1);
        end
        S_ERRW: begin
          if (div_done) begin
            sweep_q <= sweep_q + 16'd1;
            i_q     <= '0;
            j_q     <= '0;
            status_q <= (div_quot <= {32'd0, tol_q}) ? ST_SUCCESS : ST_NO_CONV;
          end
        end
        S_OLD:  out_valid_q <= 1'b1;
        S_OUT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (!out_q.last) i_q <= i_q + CW'(1);
          end
        end
        default: out_valid_q <= out_valid_q;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start_acc && bad_cfg) begin
          out_q <= '{status: ST_BAD_DATA, iterations: 16'd0, index: 6'd0,
                     solution: 32'sd0, last: 1'b1};
        end
      end
      S_CHK: begin
        acc_q <= '0;
        sd_q  <= '0;
        sx_q  <= '0;
        if (a_rd_q == 32'sd0) begin
          out_q <= '{status: ST_ZERO_DIAG, iterations: 16'd0, index: 6'd0,
                     solution: 32'sd0, last: 1'b1};
        end
      end
      S_MUL: begin
        if (j_q == i_q) begin
          diag_q <= a_rd_q;
          xi_q   <= x_rd_q;
        end
      end
      S_ACC:  if (j_q != i_q) acc_q <= acc_q + prod_sh[63:0];
      S_RES:  neg_q <= r_sat[31] ^ diag_q[31];
      S_DIVW: if (div_done) d_q <= {g_val[31], g_val} - {xi_q[31], xi_q};
      S_UPD:  xnew_q <= xnew_val;
      S_SQX:  sd_q <= sat_add64(sd_q, prod_q[63:0]);
      S_ACCX: begin
        sx_q  <= sat_add64(sx_q, prod_q[63:0]);
        acc_q <= '0;
      end
      S_SQ1W: if (sq_done) nd_q <= sq_root;
      S_ERRW: begin
        if (div_done) begin
          sd_q <= '0;
          sx_q <= '0;
        end
      end
      S_OLD: begin
        out_q <= '{status: status_q, iterations: sweep_q, index: 6'(i_q),
                   solution: x_rd_q, last: i_last};
      end
      default: acc_q <= acc_q;
    endcase
  end

endmodule

// ----- sv/sor_linear_solver_chk.sv -----
// Port-level checker for the SOR linear solver, bound to the top level.
// Depends on sor_pkg and sor_linear_solver_macros.svh.
`timescale 1ns / 1ps
`include "sor_linear_solver_macros.svh"

module sor_linear_solver_chk
  import sor_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input in_t                  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input out_t                 out_data_o
);

  // a stalled result holds
  `SOR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // no input transaction while results are being delivered
  `SOR_ASSERT_IMPL(a_busy_out, out_valid_o, in_stall_o, "input open during result delivery")

  // a start transaction makes the block busy
  `SOR_ASSERT_NEXT(a_start_busy, in_valid_i && !in_stall_o && in_data_i.action == ACT_START, in_stall_o, "not busy after start")

  // only solve results come in runs of several
  `SOR_ASSERT_IMPL(a_run_status, out_valid_o && !out_data_o.last, out_data_o.status == ST_SUCCESS || out_data_o.status == ST_NO_CONV, "error status inside a run")

  // error results are single and zero
  `SOR_ASSERT_IMPL(a_err_shape, out_valid_o && (out_data_o.status == ST_BAD_DATA || out_data_o.status == ST_ZERO_DIAG), out_data_o.last && out_data_o.iterations == 16'd0 && out_data_o.index == 6'd0 && out_data_o.solution == 32'sd0, "malformed error result")

endmodule

bind sor_linear_solver sor_linear_solver_chk u_chk (.*);

// ----- test/sor_linear_solver_tb.sv -----
// Self-checking testbench for sor_linear_solver: a table of directed transactions,
// then random load/solve sequences, checked against an SOR predictor or a typed expected status.
// Depends on sor_pkg and the sor_linear_solver RTL.
`timescale 1ns / 1ps

module sor_linear_solver_tb;
  import sor_pkg::*;

  localparam int NMAX = 16;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int RAND_ITEMS = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sor_linear_solver i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic signed [31:0] mdl_a [NMAX][NMAX];
  logic signed [31:0] mdl_b [NMAX];
  logic signed [31:0] mdl_x [NMAX];
  logic [6:0]  mdl_size = SIZE_RST;
  logic [15:0] mdl_maxit = MAX_ITER_RST;
  logic [31:0] mdl_tol = TOL_RST;
  logic [17:0] mdl_omega = OMEGA_RST;

  out_t solution_q[$];
  int errors = 0;
  int send_idle = 26;
  int recv_idle = 74;
  int idle_cycles = 0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] add_sticky(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] square_mag(longint v);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    return m * m;
  endfunction

  function automatic out_t error_result(status_e st);
    out_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // SOR solve on the predictor state; pushes the expected results
  function automatic void predict_solve();
    int n;
    int limit;
    int sweeps;
    bit done;
    bit zero_diag;
    longint acc, r, g, d, upd;
    logic signed [31:0] xold [NMAX];
    logic [63:0] sd, sx, nd, nx, err;
    out_t res;
    n = mdl_size;
    zero_diag = 0;
    if (mdl_omega == 0 || mdl_omega >= 18'(2 << FB) || n == 0 || n > NMAX || mdl_tol == 0) begin
      solution_q.push_back(error_result(ST_BAD_DATA));
      return;
    end
    for (int i = 0; i < n; i++) if (mdl_a[i][i] == 0) zero_diag = 1;
    if (zero_diag) begin
      solution_q.push_back(error_result(ST_ZERO_DIAG));
      return;
    end
    limit = (mdl_maxit == 0) ? 1 : mdl_maxit;
    xold = mdl_x;
    done = 0;
    sweeps = 0;
    for (int it = 0; it < limit && !done; it++) begin
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++) begin
          if (j != i) acc += (longint'(mdl_a[i][j]) * longint'(mdl_x[j])) >>> FB;
        end
        r = clamp32(longint'(mdl_b[i]) - acc);
        g = clamp32((r <<< FB) / longint'(mdl_a[i][i]));
        d = g - longint'(mdl_x[i]);
        upd = (d * longint'({46'd0, mdl_omega})) >>> FB;
        mdl_x[i] = clamp32(longint'(mdl_x[i]) + upd);
      end
      sd = '0;
      sx = '0;
      for (int i = 0; i < n; i++) begin
        sd = add_sticky(sd, square_mag(longint'(xold[i]) - longint'(mdl_x[i])));
        sx = add_sticky(sx, square_mag(longint'(mdl_x[i])));
      end
      nd = floor_sqrt(sd);
      nx = floor_sqrt(sx);
      err = (nd << FB) / (nx + (64'd1 << FB));
      sweeps = it + 1;
      if (err <= {32'd0, mdl_tol}) done = 1;
      else xold = mdl_x;
    end
    for (int i = 0; i < n; i++) begin
      res.status = done ? ST_SUCCESS : ST_NO_CONV;
      res.iterations = done ? 16'(sweeps) : 16'(limit);
      res.index = 6'(i);
      res.solution = mdl_x[i];
      res.last = (i + 1 == n);
      solution_q.push_back(res);
    end
  endfunction

  function automatic void predict_item(in_t it);
    case (it.action)
      ACT_MATRIX: if (it.row < NMAX && it.col < NMAX) mdl_a[it.row][it.col] = it.value;
      ACT_RHS:    if (it.row < NMAX) mdl_b[it.row] = it.value;
      ACT_GUESS:  if (it.row < NMAX) mdl_x[it.row] = it.value;
      default:    predict_solve();
    endcase
  endfunction

  // one input transaction; valid stays high afterwards unless the next call idles
  task automatic send_item(in_t it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // hold off until every expected result has arrived and the block is idle
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SIZE:     mdl_size = val[6:0];
      CFG_MAX_ITER: mdl_maxit = val[15:0];
      CFG_TOL:      mdl_tol = val;
      default:      mdl_omega = val[17:0];
    endcase
  endtask

  function automatic in_t mk(act_e a, int row, int col, logic [31:0] v);
    in_t it;
    it.action = a;
    it.row = 6'(row);
    it.col = 6'(col);
    it.value = v;
    return it;
  endfunction

  // directed table: register writes, loads, and solves
  typedef struct {
    bit is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0] data;
    in_t item;
    bit typed;
    status_e st;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    dir_row_t r;
    r = '{1'b1, idx, data, '0, 1'b0, ST_SUCCESS};
    dir_tab.push_back(r);
  endfunction

  function automatic void add_item(in_t it, bit typed, status_e st);
    dir_row_t r;
    r = '{1'b0, CFG_SIZE, 32'd0, it, typed, st};
    dir_tab.push_back(r);
  endfunction

  function automatic void build_directed();
    in_t go;
    go = mk(ACT_START, 0, 0, 32'd0);
    add_cfg(CFG_SIZE, 32'd2);
    // zero diagonal
    add_item(mk(ACT_MATRIX, 0, 0, 32'd0), 0, ST_SUCCESS);
    add_item(mk(ACT_MATRIX, 0, 1, 32'd0), 0, ST_SUCCESS);
    add_item(mk(ACT_MATRIX, 1, 0, 32'd0), 0, ST_SUCCESS);
    add_item(mk(ACT_MATRIX, 1, 1, 32'h0001_0000), 0, ST_SUCCESS);
    add_item(mk(ACT_RHS, 0, 0, 32'h0003_0000), 0, ST_SUCCESS);
    add_item(mk(ACT_RHS, 1, 0, 32'h7FFF_FFFF), 0, ST_SUCCESS);
    add_item(mk(ACT_GUESS, 0, 0, 32'd0), 0, ST_SUCCESS);
    add_item(mk(ACT_GUESS, 1, 0, 32'h8000_0000), 0, ST_SUCCESS);
    add_item(go, 1, ST_ZERO_DIAG);
    // largest diagonal, then ignored out-of-range loads
    add_item(mk(ACT_MATRIX, 0, 0, 32'h7FFF_FFFF), 0, ST_SUCCESS);
    add_item(go, 0, ST_SUCCESS);
    add_item(mk(ACT_MATRIX, 63, 63, 32'h8000_0000), 0, ST_SUCCESS);
    add_item(mk(ACT_MATRIX, 1, 16, 32'd0), 0, ST_SUCCESS);
    add_item(mk(ACT_RHS, 63, 0, 32'hFFFF_FFFF), 0, ST_SUCCESS);
    add_item(mk(ACT_GUESS, 40, 63, 32'h1234_5678), 0, ST_SUCCESS);
    add_item(mk(ACT_RHS, 1, 0, 32'h8000_0000), 0, ST_SUCCESS);
    add_item(go, 0, ST_SUCCESS);
    // relaxation factor limits
    add_cfg(CFG_OMEGA, 32'd0);
    add_item(go, 1, ST_BAD_DATA);
    add_cfg(CFG_OMEGA, 32'd131072);
    add_item(go, 1, ST_BAD_DATA);
    add_cfg(CFG_OMEGA, 32'd262143);
    add_item(go, 1, ST_BAD_DATA);
    add_cfg(CFG_MAX_ITER, 32'd0);
    add_cfg(CFG_OMEGA, 32'd131071);
    add_item(go, 0, ST_SUCCESS);
    add_cfg(CFG_OMEGA, 32'd1);
    add_item(go, 0, ST_SUCCESS);
    add_cfg(CFG_OMEGA, 32'd65536);
    // tolerance limits
    add_cfg(CFG_TOL, 32'd0);
    add_item(go, 1, ST_BAD_DATA);
    add_cfg(CFG_TOL, 32'hFFFF_FFFF);
    add_cfg(CFG_MAX_ITER, 32'd65535);
    add_item(go, 0, ST_SUCCESS);
    add_cfg(CFG_TOL, 32'd66);
    add_item(go, 0, ST_SUCCESS);
    // size limits
    add_cfg(CFG_SIZE, 32'd0);
    add_item(go, 1, ST_BAD_DATA);
    add_cfg(CFG_SIZE, 32'd17);
    add_item(go, 1, ST_BAD_DATA);
    add_cfg(CFG_SIZE, 32'd127);
    add_item(go, 1, ST_BAD_DATA);
  endfunction

  function automatic logic [31:0] rand_diag();
    logic [31:0] v;
    v = $urandom_range(32'h0040_0000, 32'h0004_0000);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic logic [31:0] rand_off();
    return 32'($signed($urandom_range(65535)) - 32768);
  endfunction

  int rand_items = 0;

  task automatic send_counted(in_t it);
    send_item(it);
    predict_item(it);
    rand_items++;
    send_idle = (rand_items < RAND_ITEMS / 3) ? 26 : (rand_items < 2 * RAND_ITEMS / 3) ? 74 : 0;
    recv_idle = (rand_items < RAND_ITEMS / 3) ? 74 : (rand_items < 2 * RAND_ITEMS / 3) ? 26 : 0;
  endtask

  // load an n-by-n system with random content and a large diagonal, diagonally dominant for n up to 8
  task automatic load_system(int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        send_counted(mk(ACT_MATRIX, i, j, (i == j) ? rand_diag() : rand_off()));
      end
      send_counted(mk(ACT_RHS, i, 0, 32'($signed($urandom) >>> $urandom_range(20, 4))));
      send_counted(mk(ACT_GUESS, i, 0, $urandom_range(3) == 0 ? $urandom : 32'd0));
    end
  endtask

  // stimulus
  initial begin
    int n;
    int kind;
    in_t it;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    build_directed();
    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) begin
        write_reg(dir_tab[k].idx, dir_tab[k].data);
      end else begin
        send_item(dir_tab[k].item);
        if (dir_tab[k].typed) begin
          solution_q.push_back(error_result(dir_tab[k].st));
        end else begin
          predict_item(dir_tab[k].item);
        end
      end
    end
    // every store entry is written before the first full-size solve
    write_reg(CFG_SIZE, 32'd16);
    write_reg(CFG_MAX_ITER, 32'd3);
    load_system(NMAX);
    send_counted(mk(ACT_START, 0, 0, 32'd0));
    while (rand_items < RAND_ITEMS) begin
      kind = $urandom_range(99);
      n = ($urandom_range(19) == 0) ? NMAX : $urandom_range(4, 2);
      // noise loads, out-of-range indexes included
      repeat ($urandom_range(3)) begin
        it = mk(act_e'($urandom_range(2)), $urandom_range(63), $urandom_range(63), $urandom);
        if (it.row < n && it.col < n) it.row = 6'($urandom_range(63, NMAX));
        send_counted(it);
      end
      write_reg(CFG_SIZE, n);
      write_reg(CFG_MAX_ITER, (n == NMAX) ? $urandom_range(3) : $urandom_range(30));
      write_reg(CFG_TOL, ($urandom_range(3) == 0) ? $urandom_range(5000, 1) : 32'd66);
      write_reg(CFG_OMEGA, ($urandom_range(3) == 0) ? $urandom_range(131071, 1)
                                                     : $urandom_range(98304, 32768));
      if (n < NMAX) load_system(n);
      if (kind < 5) write_reg(CFG_TOL, 32'd0);
      else if (kind < 10) write_reg(CFG_OMEGA, $urandom_range(262143, 131072));
      else if (kind < 13) write_reg(CFG_SIZE, $urandom_range(127, 17));
      else if (kind < 18) send_counted(mk(ACT_MATRIX, $urandom_range(n - 1), 0, 32'd0));
      if (kind >= 13 && kind < 18) begin
        it = mk(ACT_MATRIX, 0, 0, 32'd0);
        it.row = 6'($urandom_range(n - 1));
        it.col = it.row;
        send_counted(it);
      end
      send_counted(mk(ACT_START, 0, 0, 32'd0));
      // a second start continues from the stored solution
      if ($urandom_range(3) == 0) send_counted(mk(ACT_START, 0, 0, 32'd0));
    end
    wait_drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && solution_q.size() == 0) begin
      $display("sor_linear_solver test passed");
    end else begin
      $display("sor_linear_solver test failed");
    end
    $finish;
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // result checking
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (solution_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: index %0d", out_data.index);
      end else begin
        want = solution_q.pop_front();
        if (out_data.status !== want.status || out_data.iterations !== want.iterations ||
            out_data.index !== want.index || out_data.solution !== want.solution ||
            out_data.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp st=%0d it=%0d idx=%0d x=%0d last=%0d", want.status,
                     want.iterations, want.index, want.solution, want.last);
            $display("          got st=%0d it=%0d idx=%0d x=%0d last=%0d", out_data.status,
                     out_data.iterations, out_data.index, out_data.solution, out_data.last);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sor_linear_solver test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sor_pkg.sv
sv/sor_div.sv
sv/sor_isqrt.sv
sv/sor_linear_solver.sv
sv/sor_linear_solver_chk.sv
test/sor_linear_solver_tb.sv
